FILE: rtl/core/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants shared by the pixel saturation adjust block.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int unsigned CHANNEL_WIDTH = 8;
    localparam int unsigned GAIN_WIDTH    = 12;
    localparam int unsigned SQUARE_WIDTH  = 2 * CHANNEL_WIDTH;
    localparam int unsigned SUM_WIDTH     = 32;
    localparam int unsigned ROOT_WIDTH    = 16;
    localparam int unsigned REM_WIDTH     = ROOT_WIDTH + 1;
    localparam int unsigned DIFF_WIDTH    = ROOT_WIDTH + 2;
    localparam int unsigned PROD_WIDTH    = DIFF_WIDTH + GAIN_WIDTH;
    localparam int unsigned VALUE_WIDTH   = 32;

    localparam logic [15:0] WEIGHT_RED   = 16'd19595;
    localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;

    localparam logic [CHANNEL_WIDTH-1:0]       CHANNEL_MAX = 8'hFF;
    localparam logic signed [GAIN_WIDTH-1:0]   GAIN_RESET  = 12'sd256;

    localparam int unsigned ROOT_BITS_PER_STAGE = 2;
    localparam int unsigned ROOT_STAGES         = ROOT_WIDTH / ROOT_BITS_PER_STAGE;

    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0] red;
        logic [CHANNEL_WIDTH-1:0] green;
        logic [CHANNEL_WIDTH-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0]  rad;
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
    } root_t;

    // One step of the restoring square root: brings in two radicand bits
    // and decides one bit of the root.
    function automatic root_t root_step(input root_t cur);
        root_t                nxt;
        logic [REM_WIDTH+1:0] acc;
        logic [REM_WIDTH+1:0] trial;
        acc   = {cur.rem, cur.rad[SUM_WIDTH-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        nxt.rad = {cur.rad[SUM_WIDTH-3:0], 2'b00};
        if (acc >= trial)
        begin
            nxt.rem  = REM_WIDTH'(acc - trial);
            nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = REM_WIDTH'(acc);
            nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Clamps a signed Q.16 value to a channel and drops the fraction.
    function automatic logic [CHANNEL_WIDTH-1:0] clamp_channel(
        input logic signed [VALUE_WIDTH-1:0] v
    );
        logic [CHANNEL_WIDTH-1:0] c;
        if (v[VALUE_WIDTH-1])
        begin
            c = '0;
        end
        else if (|v[VALUE_WIDTH-2:24])
        begin
            c = CHANNEL_MAX;
        end
        else
        begin
            c = v[23:16];
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/psa_pixel_in_if.sv
// ----------------------------------------------------------------------------
// psa_pixel_in_if
// Input pixel channel: valid, ready and one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface psa_pixel_in_if;
    logic                                valid;
    logic                                ready;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   red_in;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   green_in;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

FILE: rtl/core/psa_pixel_out_if.sv
// ----------------------------------------------------------------------------
// psa_pixel_out_if
// Output pixel channel: valid, ready and one adjusted RGB pixel per beat.
// ----------------------------------------------------------------------------
interface psa_pixel_out_if;
    logic                                valid;
    logic                                ready;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   red_out;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   green_out;
    logic [psa_pkg::CHANNEL_WIDTH-1:0]   blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

FILE: rtl/core/psa_cfg_if.sv
// ----------------------------------------------------------------------------
// psa_cfg_if
// Configuration write channel carrying the saturation gain.
// ----------------------------------------------------------------------------
interface psa_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [psa_pkg::GAIN_WIDTH-1:0]         saturation_gain;

    modport source (output valid, output saturation_gain, input ready);
    modport sink   (input valid, input saturation_gain, output ready);
endinterface

FILE: rtl/core/pixel_saturation_adjust.sv
// ----------------------------------------------------------------------------
// pixel_saturation_adjust
// Saturation adjustment of RGB pixels about their perceived brightness.
// ----------------------------------------------------------------------------
// Pixels enter on pix_in and leave on pix_out, both valid/ready channels; a
// beat moves when valid and ready are high at a rising clock edge. The gain
// is written through cfg, which is always ready; write it only while no
// pixel is in flight.
// The pipeline has 13 register stages: squares, weighted products, sum,
// eight square root stages of two root bits each, difference times gain,
// and the add and clamp stage that is also the output register. One pixel is
// taken every cycle while nothing downstream stalls.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled receiver holds the output beat while empty
// stages upstream keep filling; no pixel is lost or repeated.
// Reset empties the pipeline and sets the gain to 1.0 (256 in Q4.8).
// ----------------------------------------------------------------------------
module pixel_saturation_adjust (
    input  logic             clk,
    input  logic             rst_n,
    psa_pixel_in_if.sink     pix_in,
    psa_pixel_out_if.source  pix_out,
    psa_cfg_if.sink          cfg
);

    localparam int unsigned ROOT_FIRST  = 3;
    localparam int unsigned MULT_STAGE  = ROOT_FIRST + psa_pkg::ROOT_STAGES;
    localparam int unsigned OUT_STAGE   = MULT_STAGE + 1;
    localparam int unsigned NUM_STAGES  = OUT_STAGE + 1;

    localparam int unsigned CW = psa_pkg::CHANNEL_WIDTH;
    localparam int unsigned QW = psa_pkg::SQUARE_WIDTH;
    localparam int unsigned SW = psa_pkg::SUM_WIDTH;
    localparam int unsigned RW = psa_pkg::ROOT_WIDTH;
    localparam int unsigned DW = psa_pkg::DIFF_WIDTH;
    localparam int unsigned PW = psa_pkg::PROD_WIDTH;
    localparam int unsigned VW = psa_pkg::VALUE_WIDTH;

    logic                                     valid_reg [NUM_STAGES];
    logic                                     load      [NUM_STAGES];
    logic                                     take      [NUM_STAGES];
    logic                                     feed      [NUM_STAGES];
    psa_pkg::pixel_t                          pixel_reg [MULT_STAGE];

    logic signed [psa_pkg::GAIN_WIDTH-1:0]    saturation_gain_reg;

    logic [QW-1:0]                            sq_red_reg;
    logic [QW-1:0]                            sq_green_reg;
    logic [QW-1:0]                            sq_blue_reg;
    logic [SW-1:0]                            wt_red_reg;
    logic [SW-1:0]                            wt_green_reg;
    logic [SW-1:0]                            wt_blue_reg;
    logic [SW-1:0]                            sum_next;
    psa_pkg::root_t                           root_reg  [psa_pkg::ROOT_STAGES+1];
    logic [RW-1:0]                            bright_reg;
    logic signed [PW-1:0]                     prod_red_reg;
    logic signed [PW-1:0]                     prod_green_reg;
    logic signed [PW-1:0]                     prod_blue_reg;
    logic signed [PW-1:0]                     prod_red_next;
    logic signed [PW-1:0]                     prod_green_next;
    logic signed [PW-1:0]                     prod_blue_next;
    logic [CW-1:0]                            red_out_reg;
    logic [CW-1:0]                            green_out_reg;
    logic [CW-1:0]                            blue_out_reg;
    logic [CW-1:0]                            red_out_next;
    logic [CW-1:0]                            green_out_next;
    logic [CW-1:0]                            blue_out_next;
    psa_pkg::pixel_t                          pixel_in_next;
    logic [RW-1:0]                            bright_next;

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_gain_reg <= psa_pkg::GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            saturation_gain_reg <= $signed(cfg.saturation_gain);
        end
    end

    // Stage handshake: a stage loads when it is empty or its successor loads.
    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++)
        begin : g_ctrl
            if (k == NUM_STAGES - 1)
            begin : g_last
                assign take[k] = pix_out.ready;
            end
            else
            begin : g_mid
                assign take[k] = load[k+1];
            end

            if (k == 0)
            begin : g_first
                assign feed[k] = pix_in.valid;
            end
            else
            begin : g_rest
                assign feed[k] = valid_reg[k-1];
            end

            assign load[k] = !valid_reg[k] || take[k];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (load[k])
                begin
                    valid_reg[k] <= feed[k];
                end
            end
        end
    endgenerate

    assign pix_in.ready = load[0];

    // Pixel carried alongside the brightness computation.
    assign pixel_in_next = '{red: pix_in.red_in, green: pix_in.green_in,
                             blue: pix_in.blue_in};

    generate
        for (k = 0; k < MULT_STAGE; k++)
        begin : g_pixel
            if (k == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (load[k])
                    begin
                        pixel_reg[k] <= pixel_in_next;
                    end
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (load[k])
                    begin
                        pixel_reg[k] <= pixel_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    // Squares, weighted products and their sum.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sq_red_reg   <= QW'(pix_in.red_in)   * QW'(pix_in.red_in);
            sq_green_reg <= QW'(pix_in.green_in) * QW'(pix_in.green_in);
            sq_blue_reg  <= QW'(pix_in.blue_in)  * QW'(pix_in.blue_in);
        end
        if (load[1])
        begin
            wt_red_reg   <= SW'(sq_red_reg)   * SW'(psa_pkg::WEIGHT_RED);
            wt_green_reg <= SW'(sq_green_reg) * SW'(psa_pkg::WEIGHT_GREEN);
            wt_blue_reg  <= SW'(sq_blue_reg)  * SW'(psa_pkg::WEIGHT_BLUE);
        end
    end

    assign sum_next = SW'({2'b00, wt_red_reg} + {2'b00, wt_green_reg}
                          + {2'b00, wt_blue_reg});

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            root_reg[0] <= '{rad: sum_next, rem: '0, root: '0};
        end
    end

    // Square root, two root bits per stage.
    generate
        for (k = 0; k < psa_pkg::ROOT_STAGES; k++)
        begin : g_root
            psa_pkg::root_t step_mid;
            psa_pkg::root_t step_next;

            assign step_mid  = psa_pkg::root_step(root_reg[k]);
            assign step_next = psa_pkg::root_step(step_mid);

            always_ff @(posedge clk)
            begin
                if (load[ROOT_FIRST+k])
                begin
                    root_reg[k+1] <= step_next;
                end
            end
        end
    endgenerate

    // Difference from the brightness, scaled by the gain.
    assign bright_next = root_reg[psa_pkg::ROOT_STAGES].root;

    always_comb
    begin
        logic signed [DW-1:0] d_red;
        logic signed [DW-1:0] d_green;
        logic signed [DW-1:0] d_blue;
        logic signed [DW-1:0] p_ext;
        p_ext   = $signed({2'b00, bright_next});
        d_red   = $signed({2'b00, pixel_reg[MULT_STAGE-1].red,   8'h00}) - p_ext;
        d_green = $signed({2'b00, pixel_reg[MULT_STAGE-1].green, 8'h00}) - p_ext;
        d_blue  = $signed({2'b00, pixel_reg[MULT_STAGE-1].blue,  8'h00}) - p_ext;
        prod_red_next   = PW'(d_red)   * PW'(saturation_gain_reg);
        prod_green_next = PW'(d_green) * PW'(saturation_gain_reg);
        prod_blue_next  = PW'(d_blue)  * PW'(saturation_gain_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[MULT_STAGE])
        begin
            bright_reg     <= bright_next;
            prod_red_reg   <= prod_red_next;
            prod_green_reg <= prod_green_next;
            prod_blue_reg  <= prod_blue_next;
        end
    end

    // Add the brightness back, clamp and drop the fraction.
    always_comb
    begin
        logic signed [VW-1:0] base;
        base           = $signed({{(VW-RW-8){1'b0}}, bright_reg, 8'h00});
        red_out_next   = psa_pkg::clamp_channel(base + VW'(prod_red_reg));
        green_out_next = psa_pkg::clamp_channel(base + VW'(prod_green_reg));
        blue_out_next  = psa_pkg::clamp_channel(base + VW'(prod_blue_reg));
    end

    always_ff @(posedge clk)
    begin
        if (load[OUT_STAGE])
        begin
            red_out_reg   <= red_out_next;
            green_out_reg <= green_out_next;
            blue_out_reg  <= blue_out_next;
        end
    end

    assign pix_out.valid     = valid_reg[OUT_STAGE];
    assign pix_out.red_out   = red_out_reg;
    assign pix_out.green_out = green_out_reg;
    assign pix_out.blue_out  = blue_out_reg;

endmodule
